// ===== src/adsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

	// Envelope geometry
	localparam int CYCLE_LEN = 2048;
	localparam int LEVEL_MAX = 4095;
	localparam int HALF_LEN  = CYCLE_LEN / 2;

	// Field and register widths
	localparam int POS_W  = $clog2(CYCLE_LEN);
	localparam int LVL_W  = 12;
	localparam int CFG_W  = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Slope divider: one quotient bit per cycle
	localparam int DIV_STEPS = LVL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Register map (word index)
	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_DECAY   = 2'd1;
	localparam logic [1:0] REG_SUSTAIN = 2'd2;
	localparam logic [1:0] REG_RELEASE = 2'd3;

	// Register reset values
	localparam logic [CFG_W-1:0] ATTACK_RST  = CFG_W'(512);
	localparam logic [CFG_W-1:0] DECAY_RST   = CFG_W'(256);
	localparam logic [CFG_W-1:0] SUSTAIN_RST = CFG_W'(2048);
	localparam logic [CFG_W-1:0] RELEASE_RST = CFG_W'(512);

	typedef enum logic [2:0] {
		ST_START   = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4,
		ST_REST    = 3'd5
	} stage_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_SUSTAIN   = 2'd1,
		ERR_ZERO_TIME = 2'd2
	} err_t;

	// One word of envelope state as kept in the state memory
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [LVL_W-1:0] cur;
		stage_t           stage;
		logic [LVL_W-1:0] rise;
		logic [LVL_W-1:0] fall;
		logic [LVL_W-1:0] rel;
	} env_state_t;

endpackage

`default_nettype wire

// ===== src/adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+-------------------------------------------
// item in   | item_valid   | item_stall   | restart
// sample out| sample_valid | sample_stall | level, sample_index, phase, config_error,
//           |              |              | cycle_last
// config    | psel/penable | pready (=1)  | paddr, pwrite, pwdata, prdata
//
// Each accepted beat passes through reading the state memory, load, evaluate and
// write back, and hand off to the output register; item_stall stays high until the hand-off.
// Sample 0 adds the two slope divisions and the first sample of release adds the
// release division, each run on the 12-step shift-subtract divider.
// Reset clears the control state and the configuration registers to their defaults;
// the state memory reads as all zero until its first write.
// A stalled output holds its beat; the finished beat waits for the output register
// and the next beat is not taken until it has moved there.
module adsr_envelope_generator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [adsr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [adsr_pkg::DATA_W-1:0] pwdata,
	output logic      [adsr_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	// item channel
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic                        restart,
	// sample channel
	output logic                             sample_valid,
	input  wire logic                        sample_stall,
	output logic      [adsr_pkg::LVL_W-1:0]  level,
	output logic      [adsr_pkg::POS_W-1:0]  sample_index,
	output logic      [2:0]                  phase,
	output logic      [1:0]                  config_error,
	output logic                             cycle_last
);

	localparam int LW = adsr_pkg::LVL_W;
	localparam int CW = adsr_pkg::CFG_W;
	localparam int PW = adsr_pkg::POS_W;
	localparam logic [adsr_pkg::DIV_CNT_W-1:0] DivLast =
		adsr_pkg::DIV_CNT_W'(adsr_pkg::DIV_STEPS - 1);
	localparam logic [adsr_pkg::DIV_CNT_W-1:0] DivOne = adsr_pkg::DIV_CNT_W'(1);
	localparam logic [PW-1:0] HalfPos  = PW'(adsr_pkg::HALF_LEN);
	localparam logic [PW-1:0] LastPos  = PW'(adsr_pkg::CYCLE_LEN - 1);
	localparam logic [PW:0]   CycleEnd = (PW + 1)'(adsr_pkg::CYCLE_LEN);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_EVAL,
		S_DIV,
		S_PUSH
	} fsm_t;

	typedef enum logic [1:0] {
		DT_RISE,
		DT_FALL,
		DT_REL
	} div_tgt_t;

	fsm_t fsm_q;

	// configuration registers
	logic [CW-1:0] attack_len_q;
	logic [CW-1:0] decay_len_q;
	logic [CW-1:0] sustain_level_q;
	logic [CW-1:0] release_len_q;
	logic          cfg_wr;

	// state memory
	adsr_pkg::env_state_t state_mem [1];
	adsr_pkg::env_state_t rd_q;
	adsr_pkg::env_state_t rd_sel;
	logic                 mem_vld_q;
	logic                 mem_re;
	logic                 mem_we;

	// working copy of the state for the beat in flight
	logic            restart_q;
	logic [PW-1:0]   pos_q;
	logic [LW-1:0]   cur_q;
	adsr_pkg::stage_t stg_q;
	logic [LW-1:0]   rise_q;
	logic [LW-1:0]   fall_q;
	logic [LW-1:0]   rel_q;
	adsr_pkg::err_t  err_q;
	adsr_pkg::err_t  cfg_err;
	logic            slopes_done_q;

	// divider
	logic [CW-1:0]                   div_rem_q;
	logic [LW-1:0]                   div_dvd_q;
	logic [CW-1:0]                   div_dvs_q;
	logic [adsr_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	div_tgt_t                        div_tgt_q;
	logic [CW:0]                     div_trial;
	logic                            div_ge;
	logic [CW-1:0]                   div_rem_nxt;
	logic [LW-1:0]                   div_quo;

	// evaluation
	logic [PW:0]          pos_inc;
	logic [PW-1:0]        pos_nxt;
	logic [LW:0]          rise_sum;
	logic [CW:0]          atk_dec_end;
	logic [CW:0]          rel_end;
	logic [CW:0]          fall_floor;
	logic [LW-1:0]        sus_lvl;
	logic                 go_att;
	logic                 in_dec;
	logic                 in_sus;
	logic                 att_ok;
	logic                 dec_win;
	logic                 dec_low;
	logic                 sus_win;
	logic                 rel_win;
	logic                 rel_low;
	logic                 ev_need_slopes;
	logic                 ev_need_rel;
	logic [LW-1:0]        ev_lvl;
	adsr_pkg::stage_t     ev_ph;
	adsr_pkg::env_state_t ev_nxt;

	// result waiting for the output register
	logic [LW-1:0]    res_lvl_q;
	logic [PW-1:0]    res_pos_q;
	adsr_pkg::stage_t res_ph_q;
	adsr_pkg::err_t   res_err_q;
	logic             res_last_q;
	logic             out_load;

	// APB: zero wait states, writes on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q    <= adsr_pkg::ATTACK_RST;
			decay_len_q     <= adsr_pkg::DECAY_RST;
			sustain_level_q <= adsr_pkg::SUSTAIN_RST;
			release_len_q   <= adsr_pkg::RELEASE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				adsr_pkg::REG_ATTACK:  attack_len_q    <= pwdata[CW-1:0];
				adsr_pkg::REG_DECAY:   decay_len_q     <= pwdata[CW-1:0];
				adsr_pkg::REG_SUSTAIN: sustain_level_q <= pwdata[CW-1:0];
				adsr_pkg::REG_RELEASE: release_len_q   <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::DATA_W'(attack_len_q);
			adsr_pkg::REG_DECAY:   prdata = adsr_pkg::DATA_W'(decay_len_q);
			adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::DATA_W'(sustain_level_q);
			adsr_pkg::REG_RELEASE: prdata = adsr_pkg::DATA_W'(release_len_q);
			default:               prdata = '0;
		endcase
	end

	// configuration check: sustain range first, then zero lengths
	always_comb begin
		if (sustain_level_q > CW'(adsr_pkg::LEVEL_MAX))
			cfg_err = adsr_pkg::ERR_SUSTAIN;
		else if (attack_len_q == '0 || decay_len_q == '0 || release_len_q == '0)
			cfg_err = adsr_pkg::ERR_ZERO_TIME;
		else
			cfg_err = adsr_pkg::ERR_NONE;
	end

	// State memory: one read at accept, one write at the end of evaluation.
	// The sequencer never lets the two meet.
	assign item_stall = (fsm_q != S_IDLE);
	assign mem_re     = item_valid && (fsm_q == S_IDLE);
	assign mem_we     = (fsm_q == S_EVAL) && !ev_need_slopes && !ev_need_rel;
	assign rd_sel     = mem_vld_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (mem_we)
			state_mem[0] <= ev_nxt;
		if (mem_re)
			rd_q <= state_mem[0];
	end

	// Shift-subtract divider step
	assign div_trial   = {div_rem_q, div_dvd_q[LW-1]};
	assign div_ge      = div_trial >= {1'b0, div_dvs_q};
	assign div_rem_nxt = div_ge ? CW'(div_trial - {1'b0, div_dvs_q}) : div_trial[CW-1:0];
	assign div_quo     = {div_dvd_q[LW-2:0], div_ge};

	// Range checks for the envelope step, all side by side
	assign pos_inc     = {1'b0, pos_q} + (PW + 1)'(1);
	assign pos_nxt     = (pos_inc >= CycleEnd) ? '0 : pos_inc[PW-1:0];
	assign rise_sum    = {1'b0, cur_q} + {1'b0, rise_q};
	assign atk_dec_end = {1'b0, attack_len_q} + {1'b0, decay_len_q};
	assign rel_end     = (CW + 1)'(adsr_pkg::HALF_LEN) + {1'b0, release_len_q};
	assign fall_floor  = (CW + 1)'(fall_q) + {1'b0, sustain_level_q};
	assign sus_lvl     = sustain_level_q[LW-1:0];

	assign go_att  = (stg_q == adsr_pkg::ST_START) || (stg_q == adsr_pkg::ST_ATTACK);
	assign in_dec  = go_att || (stg_q == adsr_pkg::ST_DECAY);
	assign in_sus  = in_dec || (stg_q == adsr_pkg::ST_SUSTAIN);
	assign sus_win = pos_q < HalfPos;
	assign att_ok  = (CW'(pos_q) < attack_len_q) && sus_win &&
		(rise_sum <= (LW + 1)'(adsr_pkg::LEVEL_MAX));
	assign dec_win = ((CW + 1)'(pos_q) < atk_dec_end) && sus_win;
	assign dec_low = (CW + 1)'(cur_q) < fall_floor;
	assign rel_win = (CW + 1)'(pos_q) < rel_end;
	assign rel_low = cur_q < rel_q;

	// One envelope step from the working state
	always_comb begin
		ev_need_slopes = 1'b0;
		ev_need_rel    = 1'b0;
		ev_lvl         = '0;
		ev_ph          = adsr_pkg::ST_REST;
		ev_nxt.pos     = pos_nxt;
		ev_nxt.cur     = cur_q;
		ev_nxt.stage   = stg_q;
		ev_nxt.rise    = rise_q;
		ev_nxt.fall    = fall_q;
		ev_nxt.rel     = rel_q;
		if (pos_q == '0) begin
			ev_ph      = adsr_pkg::ST_START;
			ev_nxt.cur = '0;
			ev_nxt.rel = '0;
			if (err_q != adsr_pkg::ERR_NONE) begin
				ev_nxt.stage = adsr_pkg::ST_REST;
			end else begin
				ev_nxt.stage   = adsr_pkg::ST_ATTACK;
				ev_need_slopes = !slopes_done_q;
			end
		end else if (err_q != adsr_pkg::ERR_NONE) begin
			ev_nxt.cur   = '0;
			ev_nxt.stage = adsr_pkg::ST_REST;
		end else if (go_att && att_ok) begin
			ev_nxt.cur = rise_sum[LW-1:0];
			ev_lvl     = rise_sum[LW-1:0];
			ev_ph      = adsr_pkg::ST_ATTACK;
		end else if (in_dec && dec_win) begin
			// decay, clamped to the sustain level
			if (dec_low) begin
				ev_nxt.cur   = sus_lvl;
				ev_lvl       = sus_lvl;
				ev_ph        = adsr_pkg::ST_SUSTAIN;
				ev_nxt.stage = adsr_pkg::ST_SUSTAIN;
			end else begin
				ev_nxt.cur   = cur_q - fall_q;
				ev_lvl       = cur_q - fall_q;
				ev_ph        = adsr_pkg::ST_DECAY;
				ev_nxt.stage = adsr_pkg::ST_DECAY;
			end
		end else if (in_sus && sus_win) begin
			ev_nxt.cur   = sus_lvl;
			ev_lvl       = sus_lvl;
			ev_ph        = adsr_pkg::ST_SUSTAIN;
			ev_nxt.stage = adsr_pkg::ST_SUSTAIN;
		end else if (in_sus) begin
			// half cycle reached: release slope first, then evaluate again
			ev_need_rel = 1'b1;
		end else if ((stg_q == adsr_pkg::ST_RELEASE) && rel_win) begin
			if (rel_low) begin
				ev_nxt.cur   = '0;
				ev_nxt.stage = adsr_pkg::ST_REST;
			end else begin
				ev_nxt.cur = cur_q - rel_q;
				ev_lvl     = cur_q - rel_q;
				ev_ph      = adsr_pkg::ST_RELEASE;
			end
		end else begin
			ev_nxt.cur   = '0;
			ev_nxt.stage = adsr_pkg::ST_REST;
		end
	end

	// Working registers, divider and pending result
	always_ff @(posedge clk) begin
		case (fsm_q)
			S_IDLE: begin
				restart_q <= restart;
			end
			S_LOAD: begin
				pos_q         <= restart_q ? '0 : rd_sel.pos;
				cur_q         <= rd_sel.cur;
				stg_q         <= rd_sel.stage;
				rise_q        <= rd_sel.rise;
				fall_q        <= rd_sel.fall;
				rel_q         <= rd_sel.rel;
				err_q         <= cfg_err;
				slopes_done_q <= 1'b0;
			end
			S_EVAL: begin
				if (ev_need_slopes) begin
					div_dvd_q <= LW'(adsr_pkg::LEVEL_MAX);
					div_dvs_q <= attack_len_q;
					div_rem_q <= '0;
					div_cnt_q <= DivLast;
					div_tgt_q <= DT_RISE;
				end else if (ev_need_rel) begin
					div_dvd_q <= cur_q;
					div_dvs_q <= release_len_q;
					div_rem_q <= '0;
					div_cnt_q <= DivLast;
					div_tgt_q <= DT_REL;
				end else begin
					res_lvl_q  <= ev_lvl;
					res_pos_q  <= pos_q;
					res_ph_q   <= ev_ph;
					res_err_q  <= err_q;
					res_last_q <= (pos_q == LastPos);
				end
			end
			S_DIV: begin
				if ((div_cnt_q == '0) && (div_tgt_q == DT_RISE)) begin
					// chain straight into the decay slope
					rise_q    <= div_quo;
					div_dvd_q <= LW'(CW'(adsr_pkg::LEVEL_MAX) - sustain_level_q);
					div_dvs_q <= decay_len_q;
					div_rem_q <= '0;
					div_cnt_q <= DivLast;
					div_tgt_q <= DT_FALL;
				end else begin
					div_rem_q <= div_rem_nxt;
					div_dvd_q <= div_quo;
					div_cnt_q <= div_cnt_q - DivOne;
					if (div_cnt_q == '0) begin
						case (div_tgt_q)
							DT_FALL: begin
								fall_q        <= div_quo;
								slopes_done_q <= 1'b1;
							end
							DT_REL: begin
								rel_q <= div_quo;
								stg_q <= adsr_pkg::ST_RELEASE;
							end
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer and output register
	assign out_load = (fsm_q == S_PUSH) && (!sample_valid || !sample_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q        <= S_IDLE;
			mem_vld_q    <= 1'b0;
			sample_valid <= 1'b0;
			level        <= '0;
			sample_index <= '0;
			phase        <= '0;
			config_error <= '0;
			cycle_last   <= 1'b0;
		end else begin
			if (mem_we)
				mem_vld_q <= 1'b1;
			if (out_load) begin
				sample_valid <= 1'b1;
				level        <= res_lvl_q;
				sample_index <= res_pos_q;
				phase        <= res_ph_q;
				config_error <= res_err_q;
				cycle_last   <= res_last_q;
			end else if (sample_valid && !sample_stall) begin
				sample_valid <= 1'b0;
			end
			case (fsm_q)
				S_IDLE: begin
					if (item_valid)
						fsm_q <= S_LOAD;
				end
				S_LOAD: begin
					fsm_q <= S_EVAL;
				end
				S_EVAL: begin
					if (ev_need_slopes || ev_need_rel)
						fsm_q <= S_DIV;
					else
						fsm_q <= S_PUSH;
				end
				S_DIV: begin
					if ((div_cnt_q == '0) && (div_tgt_q != DT_RISE))
						fsm_q <= S_EVAL;
				end
				S_PUSH: begin
					if (out_load)
						fsm_q <= S_IDLE;
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_mem_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("state memory read and write in the same cycle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == S_DIV) |-> (div_dvs_q != '0))
		else $error("divider running with a zero divisor");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == S_DIV) |-> (div_cnt_q <= DivLast))
		else $error("divider step count out of range");

	a_err_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (err_q != adsr_pkg::ERR_NONE)) |->
		((ev_lvl == '0) && (ev_nxt.stage == adsr_pkg::ST_REST)))
		else $error("configuration error did not force rest");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		((fsm_q == S_PUSH) && !sample_valid) |=> sample_valid)
		else $error("finished beat not moved to the output register");
`endif

endmodule

`default_nettype wire
